@@ rtl/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types and constants for the address resolution cache with aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int unsigned IP_W       = 32;
    localparam int unsigned MAC_W      = 48;
    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned OP_W       = 16;
    localparam int unsigned VLIFE_W    = 20;
    localparam int unsigned RETRY_W    = 17;
    localparam int unsigned PLIFE_W    = 20;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE_UP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LIFE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEND_LIFE  = 3'd4;

    localparam logic [VLIFE_W-1:0] VALID_LIFE_RST = 20'd6000;
    localparam logic [RETRY_W-1:0] RETRY_RST      = 17'd100;
    localparam logic [PLIFE_W-1:0] PEND_LIFE_RST  = 20'd500;

    localparam logic [IP_W-1:0] BCAST_IP       = '1;
    localparam logic [OP_W-1:0] ARP_OP_REQUEST = 16'd1;

    typedef enum logic [1:0] {
        FUNC_ARP     = 2'd0,
        FUNC_RESOLVE = 2'd1,
        FUNC_TICK    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STAT_HIT     = 3'd0,
        STAT_BCAST   = 3'd1,
        STAT_NEW_REQ = 3'd2,
        STAT_RETRY   = 3'd3,
        STAT_WAIT    = 3'd4,
        STAT_LEARNED = 3'd5,
        STAT_TICKED  = 3'd6
    } status_t;

    typedef struct packed {
        logic               is_valid;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

@@ rtl/arp_cache_with_aging_unit.sv @@
// ----------------------------------------------------------------------------
// ARP cache with aging
// Address resolution cache of free, pending and valid entries held in one RAM.
// ----------------------------------------------------------------------------
// A seen packet or a resolve passes through a scan of all entries, a write state and a finish
// state before its result is raised; a tick scans and then finishes, and a request that reads no
// entry goes straight to finish. One request is worked on at a time, so no new request is taken
// until the last one's result is registered; the scan is one pass of the single RAM read port.
// Reset frees every entry at once through a per-entry flag; there is no
// clearing pass, and requests are accepted as soon as reset is released.
module arp_cache_with_aging_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       func,
    input  logic [arpc_pkg::IP_W-1:0]        ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]       mac_addr,
    input  logic [arpc_pkg::OP_W-1:0]        arp_op,
    input  logic [arpc_pkg::IP_W-1:0]        target_ip,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       status,
    output logic [arpc_pkg::MAC_W-1:0]       mac_out,
    output logic                             send_reply
);

    import arpc_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_WRITE  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IW-1:0]      rd_idx_reg, rd_idx_next;
    logic [ENTRIES-1:0] used_reg, used_next;

    logic [IP_W-1:0]    own_ip_reg, own_ip_next;
    logic               iface_up_reg, iface_up_next;
    logic [VLIFE_W-1:0] vlife_reg, vlife_next;
    logic [RETRY_W-1:0] retry_reg, retry_next;
    logic [PLIFE_W-1:0] plife_reg, plife_next;
    logic [STAMP_W-1:0] tick_reg, tick_next;

    logic               match_found_reg, match_found_next;
    logic               free_found_reg, free_found_next;
    logic               out_valid_reg, out_valid_next;

    func_t              func_reg, func_next;
    logic [IP_W-1:0]    ip_reg, ip_next;
    logic [MAC_W-1:0]   mac_reg, mac_next;
    logic [IW-1:0]      match_idx_reg, match_idx_next;
    logic               match_kind_reg, match_kind_next;
    logic [STAMP_W-1:0] match_stamp_reg, match_stamp_next;
    logic [MAC_W-1:0]   match_mac_reg, match_mac_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic [IW-1:0]      old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0] old_stamp_reg, old_stamp_next;
    status_t            res_status_reg, res_status_next;
    logic [MAC_W-1:0]   res_mac_reg, res_mac_next;
    logic               res_reply_reg, res_reply_next;
    status_t            out_status_reg, out_status_next;
    logic [MAC_W-1:0]   out_mac_reg, out_mac_next;
    logic               out_reply_reg, out_reply_next;

    logic                      ram_we;
    logic [IW-1:0]             ram_waddr;
    entry_t                    ram_wdata;
    logic [IW-1:0]             ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                    rd_entry;
    logic                      rd_used;
    logic [STAMP_W-1:0]        rd_age;
    logic [STAMP_W-1:0]        match_age;
    logic [IW-1:0]             slot;

    arpc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign rd_used   = used_reg[rd_idx_reg];
    assign rd_age    = tick_reg - rd_entry.stamp;
    assign match_age = tick_reg - match_stamp_reg;
    assign slot      = match_found_reg ? match_idx_reg :
                       (free_found_reg ? free_idx_reg : old_idx_reg);

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign mac_out    = out_mac_reg;
    assign send_reply = out_reply_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = cnt_reg[IW-1:0];
        used_next        = used_reg;
        own_ip_next      = own_ip_reg;
        iface_up_next    = iface_up_reg;
        vlife_next       = vlife_reg;
        retry_next       = retry_reg;
        plife_next       = plife_reg;
        tick_next        = tick_reg;
        match_found_next = match_found_reg;
        free_found_next  = free_found_reg;
        out_valid_next   = out_valid_reg;
        func_next        = func_reg;
        ip_next          = ip_reg;
        mac_next         = mac_reg;
        match_idx_next   = match_idx_reg;
        match_kind_next  = match_kind_reg;
        match_stamp_next = match_stamp_reg;
        match_mac_next   = match_mac_reg;
        free_idx_next    = free_idx_reg;
        old_idx_next     = old_idx_reg;
        old_stamp_next   = old_stamp_reg;
        res_status_next  = res_status_reg;
        res_mac_next     = res_mac_reg;
        res_reply_next   = res_reply_reg;
        out_status_next  = out_status_reg;
        out_mac_next     = out_mac_reg;
        out_reply_next   = out_reply_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot;
        ram_wdata        = '0;
        ram_raddr        = cnt_reg[IW-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OWN_IP:     own_ip_next   = cfg_data[IP_W-1:0];
                CFG_IFACE_UP:   iface_up_next = cfg_data[0];
                CFG_VALID_LIFE: vlife_next    = cfg_data[VLIFE_W-1:0];
                CFG_RETRY:      retry_next    = cfg_data[RETRY_W-1:0];
                CFG_PEND_LIFE:  plife_next    = cfg_data[PLIFE_W-1:0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next        = func_t'(func);
                    ip_next          = ip_addr;
                    mac_next         = mac_addr;
                    res_reply_next   = (func_t'(func) == FUNC_ARP) &&
                                       (arp_op == ARP_OP_REQUEST) &&
                                       (target_ip == own_ip_reg) && iface_up_reg;
                    res_status_next  = STAT_LEARNED;
                    res_mac_next     = '0;
                    cnt_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    state_next       = S_SCAN;
                    unique case (func_t'(func))
                        FUNC_ARP:
                        begin
                            if (ip_addr == '0 || ip_addr == BCAST_IP)
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        FUNC_RESOLVE:
                        begin
                            if (ip_addr == BCAST_IP)
                            begin
                                res_status_next = STAT_BCAST;
                                res_mac_next    = '1;
                                state_next      = S_FINISH;
                            end
                        end
                        FUNC_TICK:
                        begin
                            res_status_next = STAT_TICKED;
                            if (tick_reg != '1)
                            begin
                                tick_next = tick_reg + 1'b1;
                            end
                        end
                        FUNC_NONE:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (cnt_reg < CW'(ENTRIES))
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (func_reg == FUNC_TICK)
                    begin
                        if (rd_used && rd_entry.is_valid && rd_age > STAMP_W'(vlife_reg))
                        begin
                            used_next[rd_idx_reg] = 1'b0;
                        end
                        if (rd_used && !rd_entry.is_valid && rd_age > STAMP_W'(plife_reg))
                        begin
                            used_next[rd_idx_reg] = 1'b0;
                        end
                    end
                    else
                    begin
                        if (rd_used && rd_entry.ip == ip_reg && !match_found_reg)
                        begin
                            match_found_next = 1'b1;
                            match_idx_next   = rd_idx_reg;
                            match_kind_next  = rd_entry.is_valid;
                            match_stamp_next = rd_entry.stamp;
                            match_mac_next   = rd_entry.mac;
                        end
                        if (!rd_used && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = rd_idx_reg;
                        end
                        if (rd_idx_reg == '0 || rd_entry.stamp < old_stamp_reg)
                        begin
                            old_idx_next   = rd_idx_reg;
                            old_stamp_next = rd_entry.stamp;
                        end
                    end
                end
                else if (cnt_reg == CW'(ENTRIES))
                begin
                    state_next = (func_reg == FUNC_TICK) ? S_FINISH : S_WRITE;
                end
            end

            S_WRITE:
            begin
                state_next = S_FINISH;
                if (func_reg == FUNC_ARP)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = '{is_valid: 1'b1, ip: ip_reg, mac: mac_reg,
                                        stamp: tick_reg};
                    used_next[slot] = 1'b1;
                end
                else if (match_found_reg && match_kind_reg)
                begin
                    res_status_next = STAT_HIT;
                    res_mac_next    = match_mac_reg;
                end
                else if (!match_found_reg)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = '{is_valid: 1'b0, ip: ip_reg, mac: '0,
                                        stamp: tick_reg};
                    used_next[slot] = 1'b1;
                    res_status_next = STAT_NEW_REQ;
                end
                else if (match_age >= STAMP_W'(retry_reg))
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = '{is_valid: 1'b0, ip: ip_reg, mac: match_mac_reg,
                                        stamp: tick_reg};
                    res_status_next = STAT_RETRY;
                end
                else
                begin
                    res_status_next = STAT_WAIT;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_mac_next    = res_mac_reg;
                    out_reply_next  = res_reply_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            used_reg        <= '0;
            own_ip_reg      <= '0;
            iface_up_reg    <= 1'b0;
            vlife_reg       <= VALID_LIFE_RST;
            retry_reg       <= RETRY_RST;
            plife_reg       <= PEND_LIFE_RST;
            tick_reg        <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            rd_vld_reg      <= rd_vld_next;
            rd_idx_reg      <= rd_idx_next;
            used_reg        <= used_next;
            own_ip_reg      <= own_ip_next;
            iface_up_reg    <= iface_up_next;
            vlife_reg       <= vlife_next;
            retry_reg       <= retry_next;
            plife_reg       <= plife_next;
            tick_reg        <= tick_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        ip_reg          <= ip_next;
        mac_reg         <= mac_next;
        match_idx_reg   <= match_idx_next;
        match_kind_reg  <= match_kind_next;
        match_stamp_reg <= match_stamp_next;
        match_mac_reg   <= match_mac_next;
        free_idx_reg    <= free_idx_next;
        old_idx_reg     <= old_idx_next;
        old_stamp_reg   <= old_stamp_next;
        res_status_reg  <= res_status_next;
        res_mac_reg     <= res_mac_next;
        res_reply_reg   <= res_reply_next;
        out_status_reg  <= out_status_next;
        out_mac_reg     <= out_mac_next;
        out_reply_reg   <= out_reply_next;
    end

endmodule

@@ rtl/arpc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ dv/arp_cache_with_aging_unit_test.sv @@
// ----------------------------------------------------------------------------
// ARP cache with aging testbench
// Drives seen-packet, resolve, tick and unused requests into the cache while
// both handshakes idle and stall at random. A cache model inside the bench
// predicts every result, and a checker compares each one field by field.
// ----------------------------------------------------------------------------
module arp_cache_with_aging_unit_test;

    import arpc_pkg::*;

    localparam int N_ENTRIES       = 16;
    localparam int IP_POOL         = 24;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int RANDOM_PHASES   = 7;
    localparam int HOLD_OFF_LEN    = 300;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PRINT_LIMIT     = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = '1;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_PENDING = 2'd1,
        SLOT_VALID   = 2'd2
    } slot_state_t;

    typedef struct {
        status_t          stat;
        logic [MAC_W-1:0] mac;
        logic             reply;
    } arp_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            func = '0;
    logic [IP_W-1:0]       ip_addr = '0;
    logic [MAC_W-1:0]      mac_addr = '0;
    logic [OP_W-1:0]       arp_op = '0;
    logic [IP_W-1:0]       target_ip = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            status;
    logic [MAC_W-1:0]      mac_out;
    logic                  send_reply;

    logic [IP_W-1:0]    own_ip_reg;
    logic               iface_up_reg;
    logic [VLIFE_W-1:0] valid_life_reg;
    logic [RETRY_W-1:0] retry_reg;
    logic [PLIFE_W-1:0] pend_life_reg;

    logic [IP_W-1:0]    slot_ip [N_ENTRIES];
    logic [MAC_W-1:0]   slot_mac [N_ENTRIES];
    slot_state_t        slot_state [N_ENTRIES];
    logic [STAMP_W-1:0] slot_stamp [N_ENTRIES];
    logic [STAMP_W-1:0] tick_count;

    arp_result_t expected_results[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          hold_off_cycles = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    arp_cache_with_aging_unit #(
        .ENTRIES(N_ENTRIES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .ip_addr(ip_addr),
        .mac_addr(mac_addr),
        .arp_op(arp_op),
        .target_ip(target_ip),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .mac_out(mac_out),
        .send_reply(send_reply)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_cache_model();
        own_ip_reg     = '0;
        iface_up_reg   = 1'b0;
        valid_life_reg = VALID_LIFE_RST;
        retry_reg      = RETRY_RST;
        pend_life_reg  = PEND_LIFE_RST;
        tick_count     = '0;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            slot_ip[i]    = '0;
            slot_mac[i]   = '0;
            slot_state[i] = SLOT_FREE;
            slot_stamp[i] = '0;
        end
    endfunction

    function automatic int find_entry(logic [IP_W-1:0] ip);
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            if (slot_state[i] != SLOT_FREE && slot_ip[i] == ip)
                return i;
        end
        return -1;
    endfunction

    function automatic int choose_entry(logic [IP_W-1:0] ip);
        int hit;
        int oldest;
        hit = find_entry(ip);
        oldest = 0;
        if (hit >= 0)
            return hit;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            if (slot_state[i] == SLOT_FREE)
                return i;
            if (slot_stamp[i] < slot_stamp[oldest])
                oldest = i;
        end
        return oldest;
    endfunction

    function automatic arp_result_t resolve_in_cache(func_t f, logic [IP_W-1:0] ip,
                                                     logic [MAC_W-1:0] mac,
                                                     logic [OP_W-1:0] op,
                                                     logic [IP_W-1:0] tip);
        arp_result_t r;
        int idx;
        logic [STAMP_W-1:0] age;
        r.stat  = STAT_LEARNED;
        r.mac   = '0;
        r.reply = 1'b0;
        case (f)
            FUNC_ARP:
            begin
                if (ip != '0 && ip != BCAST_IP)
                begin
                    idx = choose_entry(ip);
                    slot_ip[idx]    = ip;
                    slot_mac[idx]   = mac;
                    slot_state[idx] = SLOT_VALID;
                    slot_stamp[idx] = tick_count;
                end
                r.reply = (op == ARP_OP_REQUEST) && (tip == own_ip_reg) && iface_up_reg;
            end
            FUNC_RESOLVE:
            begin
                if (ip == BCAST_IP)
                begin
                    r.stat = STAT_BCAST;
                    r.mac  = '1;
                end
                else
                begin
                    idx = find_entry(ip);
                    if (idx >= 0 && slot_state[idx] == SLOT_VALID)
                    begin
                        r.stat = STAT_HIT;
                        r.mac  = slot_mac[idx];
                    end
                    else if (idx < 0)
                    begin
                        idx = choose_entry(ip);
                        slot_ip[idx]    = ip;
                        slot_state[idx] = SLOT_PENDING;
                        slot_stamp[idx] = tick_count;
                        r.stat = STAT_NEW_REQ;
                    end
                    else
                    begin
                        age = tick_count - slot_stamp[idx];
                        if (age >= STAMP_W'(retry_reg))
                        begin
                            slot_stamp[idx] = tick_count;
                            r.stat = STAT_RETRY;
                        end
                        else
                            r.stat = STAT_WAIT;
                    end
                end
            end
            FUNC_TICK:
            begin
                if (tick_count != '1)
                    tick_count = tick_count + 1'b1;
                for (int i = 0; i < N_ENTRIES; i++)
                begin
                    age = tick_count - slot_stamp[i];
                    if (slot_state[i] == SLOT_VALID && age > STAMP_W'(valid_life_reg))
                        slot_state[i] = SLOT_FREE;
                    else if (slot_state[i] == SLOT_PENDING && age > STAMP_W'(pend_life_reg))
                        slot_state[i] = SLOT_FREE;
                end
                r.stat = STAT_TICKED;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int burst_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("ERROR: %s got %h expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_OWN_IP:     own_ip_reg = data;
            CFG_IFACE_UP:   iface_up_reg = data[0];
            CFG_VALID_LIFE: valid_life_reg = data[VLIFE_W-1:0];
            CFG_RETRY:      retry_reg = data[RETRY_W-1:0];
            CFG_PEND_LIFE:  pend_life_reg = data[PLIFE_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(func_t f, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                logic [OP_W-1:0] op, logic [IP_W-1:0] tip);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : burst_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        ip_addr   <= ip;
        mac_addr  <= mac;
        arp_op    <= op;
        target_ip <= tip;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(resolve_in_cache(f, ip, mac, op, tip));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_request(logic [IP_W-1:0] pool_base);
        int sel;
        logic [IP_W-1:0] ip;
        logic [MAC_W-1:0] mac;
        logic [OP_W-1:0] op;
        logic [IP_W-1:0] tip;
        func_t f;
        sel = $urandom_range(0, 99);
        ip = pool_base + IP_W'($urandom_range(0, IP_POOL - 1));
        case ($urandom_range(0, 29))
            0: ip = $urandom;
            1: ip = '0;
            2: ip = BCAST_IP;
            default:
            begin
            end
        endcase
        mac = {16'($urandom), 32'($urandom)};
        op  = ($urandom_range(0, 99) < 60) ? ARP_OP_REQUEST : OP_W'($urandom);
        tip = $urandom_range(0, 1) ? own_ip_reg : IP_W'($urandom);
        if (sel < 35)
            f = FUNC_ARP;
        else if (sel < 70)
            f = FUNC_RESOLVE;
        else if (sel < 95)
            f = FUNC_TICK;
        else
            f = FUNC_NONE;
        send_request(f, ip, mac, op, tip);
    endtask

    task automatic test_reset_defaults();
        logic [IP_W-1:0] hop;
        hop = 32'hAC10_0A01;
        send_request(FUNC_RESOLVE, BCAST_IP, '0, '0, '0);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
        send_request(FUNC_ARP, hop, '1, ARP_OP_REQUEST, '0);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
        send_request(FUNC_ARP, '0, 48'h0000_0000_0001, ARP_OP_REQUEST, '0);
        send_request(FUNC_ARP, BCAST_IP, '0, '1, '1);
        send_request(FUNC_NONE, '1, '1, '1, '1);
        send_request(FUNC_TICK, '0, '0, '0, '0);
    endtask

    task automatic test_reply_rules();
        logic [IP_W-1:0] me;
        me = 32'hAC10_0105;
        wait_drained();
        write_register(CFG_OWN_IP, me);
        write_register(CFG_IFACE_UP, '1);
        send_request(FUNC_ARP, 32'hAC10_0107, 48'h0200_0000_0007, ARP_OP_REQUEST, me);
        send_request(FUNC_ARP, 32'hAC10_0107, 48'h0200_0000_0008, '1, me);
        send_request(FUNC_ARP, 32'hAC10_0108, '0, ARP_OP_REQUEST, me ^ 32'h1);
        send_request(FUNC_ARP, '0, '1, ARP_OP_REQUEST, me);
        send_request(FUNC_ARP, BCAST_IP, '1, ARP_OP_REQUEST, me);
        wait_drained();
        write_register(CFG_IFACE_UP, 32'h2);
        send_request(FUNC_ARP, 32'hAC10_0109, '1, ARP_OP_REQUEST, me);
    endtask

    task automatic test_retry_and_expiry();
        logic [IP_W-1:0] hop;
        hop = 32'hAC10_0C01;
        wait_drained();
        write_register(CFG_VALID_LIFE, 32'd3);
        write_register(CFG_RETRY, 32'h0002_0001);
        write_register(CFG_PEND_LIFE, 32'd2);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
        send_request(FUNC_TICK, '0, '0, '0, '0);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
        repeat (3) send_request(FUNC_TICK, '0, '0, '0, '0);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
        send_request(FUNC_ARP, hop, 48'h0A0B_0C0D_0E0F, '0, '0);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
        repeat (4) send_request(FUNC_TICK, '0, '0, '0, '0);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
        wait_drained();
        write_register(CFG_RETRY, 32'h0);
        send_request(FUNC_RESOLVE, hop, '0, '0, '0);
    endtask

    task automatic test_backpressure();
        logic [IP_W-1:0] pool_base;
        pool_base = $urandom;
        wait_drained();
        calm = 1'b1;
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (12) send_random_request(pool_base);
        calm = 1'b0;
    endtask

    task automatic test_random_settings();
        logic [IP_W-1:0] pool_base;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    write_register(CFG_OWN_IP, $urandom);
                    write_register(CFG_IFACE_UP, 32'h1);
                    write_register(CFG_VALID_LIFE, 32'd8);
                    write_register(CFG_RETRY, 32'd2);
                    write_register(CFG_PEND_LIFE, 32'd4);
                    for (int k = CFG_PEND_LIFE + 1; k <= CFG_SPARE_LAST; k++)
                        write_register(CFG_IDX_W'(k), $urandom);
                end
                1:
                begin
                    write_register(CFG_VALID_LIFE, 32'd1);
                    write_register(CFG_RETRY, 32'd1);
                    write_register(CFG_PEND_LIFE, 32'd1);
                end
                2:
                begin
                    write_register(CFG_VALID_LIFE, 32'h0010_0005);
                    write_register(CFG_RETRY, 32'h0002_0000);
                    write_register(CFG_PEND_LIFE, 32'hFFF0_0003);
                end
                3:
                begin
                    write_register(CFG_IFACE_UP, 32'h0);
                    write_register(CFG_VALID_LIFE, 32'd1000000);
                    write_register(CFG_RETRY, 32'd100000);
                    write_register(CFG_PEND_LIFE, 32'd1000000);
                end
                4:
                begin
                    write_register(CFG_IFACE_UP, 32'hFFFF_FFFF);
                    write_register(CFG_VALID_LIFE, 32'h000F_FFFF);
                    write_register(CFG_RETRY, 32'h0001_FFFF);
                    write_register(CFG_PEND_LIFE, 32'h000F_FFFF);
                end
                5:
                begin
                    write_register(CFG_OWN_IP, 32'hFFFF_FFFF);
                    write_register(CFG_VALID_LIFE, $urandom_range(1, 30));
                    write_register(CFG_RETRY, $urandom_range(0, 10));
                    write_register(CFG_PEND_LIFE, $urandom_range(1, 20));
                end
                default:
                begin
                    write_register(CFG_OWN_IP, 32'h0);
                    write_register(CFG_VALID_LIFE, $urandom_range(1, 30));
                    write_register(CFG_RETRY, $urandom_range(0, 10));
                    write_register(CFG_PEND_LIFE, $urandom_range(1, 20));
                end
            endcase
            pool_base = $urandom;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_random_request(pool_base);
            end
            calm = 1'b0;
        end
    endtask

    // The receiver side: a requested hold-off wins over the random stall bursts.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            out_stall <= 1'b1;
            stall_left = burst_len() - 1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        arp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no request pending, status", 64'(status), '0);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.stat)
                    report_mismatch("status", 64'(status), 64'(want.stat));
                if (mac_out !== want.mac)
                    report_mismatch("mac_out", 64'(mac_out), 64'(want.mac));
                if (send_reply !== want.reply)
                    report_mismatch("send_reply", 64'(send_reply), 64'(want.reply));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("arp_cache_with_aging_unit: mismatch");
        $finish;
    end

    initial
    begin
        clear_cache_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_reply_rules();
        test_retry_and_expiry();
        test_backpressure();
        test_random_settings();
        wait_drained();
        repeat (N_ENTRIES + 8) @(posedge clk);
        if (mismatches == 0)
            $display("arp_cache_with_aging_unit: match");
        else
            $display("arp_cache_with_aging_unit: mismatch");
        $finish;
    end

endmodule

@@ arp_cache_with_aging_unit.f @@
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arp_cache_with_aging_unit.sv
dv/arp_cache_with_aging_unit_test.sv
